// ===== hdl/vdr_pkg.sv =====
// Shared constants for the vertex dedup / index remap engine.
// Sizes of the stores, field widths, command and status codes.
// No dependencies.
package vdr_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int MAX_STREAMS  = 4;
  localparam int VIDX_W       = 8;
  localparam int SIDX_W       = 2;
  localparam int SLOT_W       = SIDX_W + VIDX_W;
  localparam int SLOTS        = MAX_STREAMS * MAX_VERTICES;
  localparam int ELEM_W       = 128;
  localparam int CNT_W        = 9;
  localparam int MAP_W        = 1 + 2 * VIDX_W;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] STS_LOAD  = 2'd0;
  localparam logic [1:0] STS_BUILD = 2'd1;
  localparam logic [1:0] STS_QUERY = 2'd2;

  localparam logic [1:0] REG_VCOUNT = 2'd0;
  localparam logic [1:0] REG_SCOUNT = 2'd1;
  localparam logic [1:0] REG_TYPES  = 2'd2;
  localparam logic [1:0] REG_DEPS   = 2'd3;

endpackage

// ===== hdl/vdr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module vdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/vdr_cmp.sv =====
// Element compare unit: low bytes of two elements, width set by the type code.
// Depends on vdr_pkg.
module vdr_cmp (
  input  logic [vdr_pkg::ELEM_W-1:0] a,
  input  logic [vdr_pkg::ELEM_W-1:0] b,
  input  logic [3:0]                 code,
  output logic                       eq
);
  import vdr_pkg::*;

  localparam int NBYTES = ELEM_W / 8;

  logic [NBYTES-1:0] bmask;
  logic [NBYTES-1:0] bdiff;

  always_comb begin
    case (code)
      4'd1:    bmask = 16'h0001;
      4'd2:    bmask = 16'h0003;
      4'd3:    bmask = 16'h0007;
      4'd4:    bmask = 16'h000F;
      4'd6:    bmask = 16'h000F;
      4'd7:    bmask = 16'h00FF;
      4'd8:    bmask = 16'h0FFF;
      4'd9:    bmask = 16'hFFFF;
      4'd10:   bmask = 16'h000F;
      default: bmask = 16'h0000;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NBYTES; i++) begin
      bdiff[i] = (a[8*i +: 8] != b[8*i +: 8]);
    end
  end

  assign eq = (bmask != '0) && ((bdiff & bmask) == '0);

endmodule

// ===== hdl/vertex_dedup_remap_top.sv =====
// Vertex dedup / index remap engine: top level with command sequencer.
// Depends on vdr_pkg, vdr_ram (element and map stores), vdr_cmp.
//
// Usage:
//  in_*  : one command per item. in_tuser = command (load, build, query);
//          in_tdata = stream, vertex index, element bytes 0..15.
//  out_* : one result per load, build or query; command 3 gives none.
//          out_tuser = status; out_tdata = representative, duplicate flag,
//          compacted index, kept count of the stream.
//  cfg_* : register writes (vertex count, stream count, types, dep masks),
//          only while the engine is idle.
//  Loads are written to the element RAM at acceptance and complete at one
//  per cycle while out_tready is high. A query makes one or two dependent
//  map RAM reads. A build clears all 1024 map RAM entries, then per stream
//  in use checks each source, loads the elements of each unmerged source,
//  compares each candidate pair (four element RAM reads) and runs a
//  removed-count sweep over the stream's 256 map entries: quadratic in vertex_count.
//  After reset the map RAM is cleared; in_tready is low meanwhile.
//  A result waiting on a stalled receiver holds in the output register;
//  one more item may then be taken, and in_tready stays low until its result is passed on.
module vertex_dedup_remap_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,    // command
  input  logic [143:0] in_tdata,    // stream_select, vertex_index, data_low, data_high
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,   // status
  output logic [31:0]  out_tdata,   // representative, is_duplicate, compacted_index,
                                    // stream_kept_count
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import vdr_pkg::*;

  localparam logic [3:0] ST_CLR     = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_RESULT  = 4'd2;
  localparam logic [3:0] ST_Q1      = 4'd3;
  localparam logic [3:0] ST_Q2      = 4'd4;
  localparam logic [3:0] ST_SBEGIN  = 4'd5;
  localparam logic [3:0] ST_SRCCHK  = 4'd6;
  localparam logic [3:0] ST_SRCMRG  = 4'd7;
  localparam logic [3:0] ST_SRCLD   = 4'd8;
  localparam logic [3:0] ST_CAND    = 4'd9;
  localparam logic [3:0] ST_CMP     = 4'd10;
  localparam logic [3:0] ST_SWEEP   = 4'd11;
  localparam logic [3:0] ST_SNEXT   = 4'd12;

  logic [3:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] clr_r, clr_nxt;
  logic              bld_r, bld_nxt;
  logic [SIDX_W-1:0] s_r, s_nxt;
  logic [CNT_W-1:0]  src_r, src_nxt;
  logic [CNT_W-1:0]  cand_r, cand_nxt;
  logic [CNT_W-1:0]  v_r, v_nxt;
  logic [2:0]        ph_r, ph_nxt;
  logic              eq_r, eq_nxt;
  logic [VIDX_W-1:0] rm_r, rm_nxt;
  logic [VIDX_W-1:0] qv_r, qv_nxt;
  logic              qdup_r, qdup_nxt;
  logic [CNT_W-1:0]  kept_r [MAX_STREAMS];
  logic [CNT_W-1:0]  kept_nxt [MAX_STREAMS];
  logic [ELEM_W-1:0] src_elem_r [MAX_STREAMS];

  logic [1:0]        res_sts_r, res_sts_nxt;
  logic [VIDX_W-1:0] res_rep_r, res_rep_nxt;
  logic              res_dup_r, res_dup_nxt;
  logic [VIDX_W-1:0] res_cmp_r, res_cmp_nxt;
  logic [CNT_W-1:0]  res_kept_r, res_kept_nxt;

  logic              out_valid_r;
  logic [1:0]        out_sts_r;
  logic [VIDX_W-1:0] out_rep_r;
  logic              out_dup_r;
  logic [VIDX_W-1:0] out_cmp_r;
  logic [CNT_W-1:0]  out_kept_r;

  logic [8:0]  vcount_r;
  logic [2:0]  scount_r;
  logic [15:0] types_r;
  logic [15:0] deps_r;

  logic [CNT_W-1:0] n_eff;
  logic [2:0]       ns_eff;
  logic [3:0]       deps_s;
  logic             out_free;
  logic             in_acc;
  logic             push_load;
  logic             push_res;

  logic              e_we;
  logic [SLOT_W-1:0] e_waddr, e_raddr;
  logic [ELEM_W-1:0] e_wdata, e_rdata;
  logic              m_we;
  logic [SLOT_W-1:0] m_waddr, m_raddr;
  logic [MAP_W-1:0]  m_wdata, m_rdata;

  logic [1:0]  cmp_d;
  logic [3:0]  cmp_code;
  logic        cmp_eq;
  logic        need_d;

  logic [1:0]        in_s;
  logic [VIDX_W-1:0] in_v;

  assign in_s = in_tdata[1:0];
  assign in_v = in_tdata[9:2];

  assign n_eff   = (vcount_r > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_r;
  assign ns_eff  = (scount_r > 3'(MAX_STREAMS)) ? 3'(MAX_STREAMS) : scount_r;
  assign deps_s  = deps_r[4*s_r +: 4];
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign cmp_d    = 2'(ph_r - 3'd1);
  assign cmp_code = types_r[4*cmp_d +: 4];
  assign need_d   = (cmp_d == s_r) || (deps_s[cmp_d] && ({1'b0, cmp_d} < ns_eff));

  vdr_cmp u_cmp (
    .a    (src_elem_r[cmp_d]),
    .b    (e_rdata),
    .code (cmp_code),
    .eq   (cmp_eq)
  );

  vdr_ram #(.WIDTH(ELEM_W), .DEPTH(SLOTS)) u_elem_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  vdr_ram #(.WIDTH(MAP_W), .DEPTH(SLOTS)) u_map_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  assign e_we    = in_acc && (in_tuser == CMD_LOAD);
  assign e_waddr = {in_s, in_v};
  assign e_wdata = {in_tdata[137:74], in_tdata[73:10]};

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    bld_nxt      = bld_r;
    s_nxt        = s_r;
    src_nxt      = src_r;
    cand_nxt     = cand_r;
    v_nxt        = v_r;
    ph_nxt       = ph_r;
    eq_nxt       = eq_r;
    rm_nxt       = rm_r;
    qv_nxt       = qv_r;
    qdup_nxt     = qdup_r;
    kept_nxt     = kept_r;
    res_sts_nxt  = res_sts_r;
    res_rep_nxt  = res_rep_r;
    res_dup_nxt  = res_dup_r;
    res_cmp_nxt  = res_cmp_r;
    res_kept_nxt = res_kept_r;
    push_load    = 1'b0;
    push_res     = 1'b0;
    e_raddr      = {s_r, src_r[VIDX_W-1:0]};
    m_raddr      = {s_r, src_r[VIDX_W-1:0]};
    m_we         = 1'b0;
    m_waddr      = clr_r;
    m_wdata      = '0;

    case (state_r)
      ST_CLR: begin
        m_we    = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          if (bld_r) begin
            s_nxt     = '0;
            state_nxt = ST_SBEGIN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        m_raddr = {in_s, in_v};
        if (in_acc) begin
          case (in_tuser)
            CMD_LOAD: begin
              if (out_free) begin
                push_load = 1'b1;
              end else begin
                res_sts_nxt  = STS_LOAD;
                res_rep_nxt  = '0;
                res_dup_nxt  = 1'b0;
                res_cmp_nxt  = '0;
                res_kept_nxt = '0;
                state_nxt    = ST_RESULT;
              end
            end
            CMD_BUILD: begin
              bld_nxt   = 1'b1;
              clr_nxt   = '0;
              state_nxt = ST_CLR;
            end
            CMD_QUERY: begin
              s_nxt     = in_s;
              qv_nxt    = in_v;
              state_nxt = ST_Q1;
            end
            default: ;
          endcase
        end
      end
      ST_Q1: begin
        m_raddr = {s_r, m_rdata[15:8]};
        if (m_rdata[16]) begin
          qv_nxt    = m_rdata[15:8];
          qdup_nxt  = 1'b1;
          state_nxt = ST_Q2;
        end else begin
          res_sts_nxt  = STS_QUERY;
          res_rep_nxt  = qv_r;
          res_dup_nxt  = 1'b0;
          res_cmp_nxt  = qv_r - m_rdata[7:0];
          res_kept_nxt = kept_r[s_r];
          state_nxt    = ST_RESULT;
        end
      end
      ST_Q2: begin
        res_sts_nxt  = STS_QUERY;
        res_rep_nxt  = qv_r;
        res_dup_nxt  = qdup_r;
        res_cmp_nxt  = qv_r - m_rdata[7:0];
        res_kept_nxt = kept_r[s_r];
        qdup_nxt     = 1'b0;
        state_nxt    = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          push_res  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SBEGIN: begin
        src_nxt = '0;
        if ({1'b0, s_r} < ns_eff) begin
          kept_nxt[s_r] = n_eff;
          state_nxt     = ST_SRCCHK;
        end else begin
          kept_nxt[s_r] = '0;
          state_nxt     = ST_SNEXT;
        end
      end
      ST_SRCCHK: begin
        if (src_r >= n_eff) begin
          v_nxt     = '0;
          ph_nxt    = '0;
          rm_nxt    = '0;
          state_nxt = ST_SWEEP;
        end else begin
          state_nxt = ST_SRCMRG;
        end
      end
      ST_SRCMRG: begin
        ph_nxt = '0;
        if (m_rdata[16]) begin
          src_nxt   = src_r + 1'b1;
          state_nxt = ST_SRCCHK;
        end else begin
          state_nxt = ST_SRCLD;
        end
      end
      ST_SRCLD: begin
        e_raddr = {ph_r[1:0], src_r[VIDX_W-1:0]};
        ph_nxt  = ph_r + 1'b1;
        if (ph_r == 3'd4) begin
          cand_nxt  = src_r + 1'b1;
          state_nxt = ST_CAND;
        end
      end
      ST_CAND: begin
        ph_nxt = '0;
        eq_nxt = 1'b1;
        if (cand_r >= n_eff) begin
          src_nxt   = src_r + 1'b1;
          state_nxt = ST_SRCCHK;
        end else begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        e_raddr = {ph_r[1:0], cand_r[VIDX_W-1:0]};
        ph_nxt  = ph_r + 1'b1;
        if (ph_r != 3'd0 && need_d && !cmp_eq) begin
          eq_nxt = 1'b0;
        end
        if (ph_r == 3'd4) begin
          if (eq_r && !(need_d && !cmp_eq)) begin
            m_we          = 1'b1;
            m_waddr       = {s_r, cand_r[VIDX_W-1:0]};
            m_wdata       = {1'b1, src_r[VIDX_W-1:0], 8'd0};
            kept_nxt[s_r] = kept_r[s_r] - 1'b1;
          end
          cand_nxt  = cand_r + 1'b1;
          state_nxt = ST_CAND;
        end
      end
      ST_SWEEP: begin
        m_raddr = {s_r, v_r[VIDX_W-1:0]};
        if (ph_r[0]) begin
          m_we    = 1'b1;
          m_waddr = {s_r, v_r[VIDX_W-1:0]};
          m_wdata = {m_rdata[16:8], rm_r};
          if (m_rdata[16]) begin
            rm_nxt = rm_r + 1'b1;
          end
          v_nxt  = v_r + 1'b1;
          ph_nxt = '0;
          if (v_r == CNT_W'(MAX_VERTICES - 1)) begin
            state_nxt = ST_SNEXT;
          end
        end else begin
          ph_nxt = 3'd1;
        end
      end
      ST_SNEXT: begin
        if (s_r == SIDX_W'(MAX_STREAMS - 1)) begin
          bld_nxt      = 1'b0;
          res_sts_nxt  = STS_BUILD;
          res_rep_nxt  = '0;
          res_dup_nxt  = 1'b0;
          res_cmp_nxt  = '0;
          res_kept_nxt = '0;
          state_nxt    = ST_RESULT;
        end else begin
          s_nxt     = s_r + 1'b1;
          state_nxt = ST_SBEGIN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      bld_r       <= 1'b0;
      s_r         <= '0;
      src_r       <= '0;
      cand_r      <= '0;
      v_r         <= '0;
      ph_r        <= '0;
      eq_r        <= 1'b0;
      rm_r        <= '0;
      qdup_r      <= 1'b0;
      out_valid_r <= 1'b0;
      vcount_r    <= 9'd256;
      scount_r    <= 3'd1;
      types_r     <= '0;
      deps_r      <= '0;
      for (int i = 0; i < MAX_STREAMS; i++) begin
        kept_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      bld_r   <= bld_nxt;
      s_r     <= s_nxt;
      src_r   <= src_nxt;
      cand_r  <= cand_nxt;
      v_r     <= v_nxt;
      ph_r    <= ph_nxt;
      eq_r    <= eq_nxt;
      rm_r    <= rm_nxt;
      qdup_r  <= qdup_nxt;
      kept_r  <= kept_nxt;
      if (push_load || push_res) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VCOUNT: vcount_r <= cfg_data[8:0];
          REG_SCOUNT: scount_r <= cfg_data[2:0];
          REG_TYPES:  types_r  <= cfg_data;
          REG_DEPS:   deps_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    qv_r       <= qv_nxt;
    res_sts_r  <= res_sts_nxt;
    res_rep_r  <= res_rep_nxt;
    res_dup_r  <= res_dup_nxt;
    res_cmp_r  <= res_cmp_nxt;
    res_kept_r <= res_kept_nxt;
    if (state_r == ST_SRCLD && ph_r != 3'd0) begin
      src_elem_r[cmp_d] <= e_rdata;
    end
    if (push_load) begin
      out_sts_r  <= STS_LOAD;
      out_rep_r  <= '0;
      out_dup_r  <= 1'b0;
      out_cmp_r  <= '0;
      out_kept_r <= '0;
    end else if (push_res) begin
      out_sts_r  <= res_sts_r;
      out_rep_r  <= res_rep_r;
      out_dup_r  <= res_dup_r;
      out_cmp_r  <= res_cmp_r;
      out_kept_r <= res_kept_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_sts_r;
  assign out_tdata  = {6'd0, out_kept_r, out_cmp_r, out_dup_r, out_rep_r};

endmodule
